@@ design/fpa_pkg.sv @@
// Package for the Q24.8 fixed-point ALU: command codes, default widths and
// the queue entry type. Depends on nothing.
package fpa_pkg;
  localparam int FRACTION_BITS_DEF = 8;
  localparam int WORD_BITS_DEF = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [3:0] CMD_ADD = 4'd0;
  localparam logic [3:0] CMD_SUB = 4'd1;
  localparam logic [3:0] CMD_MUL = 4'd2;
  localparam logic [3:0] CMD_DIV = 4'd3;
  localparam logic [3:0] CMD_MIN = 4'd4;
  localparam logic [3:0] CMD_MAX = 4'd5;
  localparam logic [3:0] CMD_CMP = 4'd6;
  localparam logic [3:0] CMD_I2F = 4'd7;
  localparam logic [3:0] CMD_F2I = 4'd8;
  localparam logic [3:0] CMD_INC = 4'd9;
  localparam logic [3:0] CMD_DEC = 4'd10;

  // Classified request as it sits in the queue.
  typedef struct packed {
    logic [3:0]         command;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic               lt;
    logic               eq;
    logic               gt;
  } fpa_req_t;
endpackage

@@ design/fpa_if.sv @@
// Valid/ready channel interfaces for the fixed-point ALU.
// Depends on fpa_pkg.
interface fpa_in_if import fpa_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [3:0]  command;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  modport source (output valid, command, operand_a, operand_b, input ready);
  modport sink (input valid, command, operand_a, operand_b, output ready);
endinterface

interface fpa_out_if import fpa_pkg::*; ();
  logic        valid;
  logic        ready;
  logic signed [31:0] result;
  logic        a_less;
  logic        a_equal;
  logic        a_greater;
  logic        divide_by_zero;
  modport source (output valid, result, a_less, a_equal, a_greater, divide_by_zero,
                  input ready);
  modport sink (input valid, result, a_less, a_equal, a_greater, divide_by_zero,
                output ready);
endinterface

@@ design/fpa_front.sv @@
// Front end: narrows operands to the word width, compares them and pushes
// a classified request into a short queue. Depends on fpa_pkg.
module fpa_front import fpa_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic [3:0] in_command,
  input  logic [31:0] in_a,
  input  logic [31:0] in_b,
  output logic     q_valid,
  input  logic     q_ready,
  output fpa_req_t q_req
);
  localparam int PW = $clog2(QUEUE_DEPTH);
  fpa_req_t mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0] cnt_r, cnt_nxt;
  logic signed [31:0] a_s, b_s;
  fpa_req_t req;
  logic push, pop;

  assign a_s = 32'(signed'(in_a[WORD_BITS-1:0]));
  assign b_s = 32'(signed'(in_b[WORD_BITS-1:0]));
  always_comb begin
    req.command = in_command;
    req.a = a_s;
    req.b = b_s;
    req.lt = a_s < b_s;
    req.eq = a_s == b_s;
    req.gt = a_s > b_s;
  end

  assign in_ready = cnt_r != (PW+1)'(QUEUE_DEPTH);
  assign q_valid = cnt_r != '0;
  assign q_req = mem_r[rp_r];
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;
  assign wp_nxt = push ? PW'(wp_r + 1'b1) : wp_r;
  assign rp_nxt = pop ? PW'(rp_r + 1'b1) : rp_r;
  assign cnt_nxt = cnt_r + (PW+1)'(push) - (PW+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wp_r] <= req;
  end
endmodule

@@ design/fpa_back.sv @@
// Back end: pipelined execution of one request per cycle while the output
// is not stalled. A restoring divider gives one quotient bit a stage; the
// multiplier has one stage. Depends on fpa_pkg.
module fpa_back import fpa_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_valid,
  output logic     q_ready,
  input  fpa_req_t q_req,
  output logic     out_valid,
  input  logic     out_ready,
  output logic signed [31:0] out_result,
  output logic     out_lt,
  output logic     out_eq,
  output logic     out_gt,
  output logic     out_dbz
);
  // Dividend magnitude width: |a| << FRACTION_BITS.
  localparam int NW = WORD_BITS + FRACTION_BITS + 1;
  localparam int DW = WORD_BITS + 1;
  localparam int ST = NW + 2;

  typedef struct packed {
    logic [3:0]         command;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic               lt, eq, gt;
    logic [NW-1:0]      num;
    logic [DW-1:0]      den;
    logic [DW:0]        rem;
    logic [NW-1:0]      quo;
    logic               neg;
    logic signed [63:0] prod;
  } stage_t;

  stage_t st_r [ST];
  stage_t st_nxt [ST];
  logic   v_r [ST];
  logic   adv;
  stage_t s0;

  function automatic logic signed [31:0] fin(stage_t s);
    logic [63:0] r;
    logic [NW-1:0] q;
    r = '0;
    q = s.neg ? NW'(-s.quo) : s.quo;
    case (s.command)
      CMD_ADD: r = 64'(s.a) + 64'(s.b);
      CMD_SUB: r = 64'(s.a) - 64'(s.b);
      CMD_MUL: r = 64'(s.prod >>> FRACTION_BITS);
      CMD_DIV: r = (s.den == '0) ? 64'd0 : 64'(q);
      CMD_MIN: r = s.lt ? 64'(s.a) : 64'(s.b);
      CMD_MAX: r = s.gt ? 64'(s.a) : 64'(s.b);
      CMD_I2F: r = 64'(s.a) << FRACTION_BITS;
      CMD_F2I: r = 64'(s.a >>> FRACTION_BITS);
      CMD_INC: r = 64'(s.a) + 64'd1;
      CMD_DEC: r = 64'(s.a) - 64'd1;
      default: r = '0;
    endcase
    return 32'(signed'(r[WORD_BITS-1:0]));
  endfunction

  assign adv = !v_r[ST-1] || out_ready;
  assign q_ready = adv;

  always_comb begin
    logic signed [NW-1:0] sa;
    logic signed [DW-1:0] sb;
    sa = NW'(signed'(q_req.a[WORD_BITS-1:0])) <<< FRACTION_BITS;
    sb = DW'(signed'(q_req.b[WORD_BITS-1:0]));
    s0 = '0;
    s0.command = q_req.command;
    s0.a = q_req.a;
    s0.b = q_req.b;
    s0.lt = q_req.lt;
    s0.eq = q_req.eq;
    s0.gt = q_req.gt;
    s0.num = sa[NW-1] ? NW'(-sa) : NW'(sa);
    s0.den = sb[DW-1] ? DW'(-sb) : DW'(sb);
    s0.neg = sa[NW-1] ^ sb[DW-1];
  end

  // Stage 0 multiplies; stages 1..NW each make one quotient bit; the last
  // stage forms the result and the zero-divisor flag.
  always_comb begin
    logic [DW:0] t;
    st_nxt[0] = s0;
    st_nxt[0].prod = 64'(q_req.a) * 64'(q_req.b);
    for (int i = 1; i <= NW; i++) begin
      st_nxt[i] = st_r[i-1];
      t = {st_r[i-1].rem[DW-1:0], st_r[i-1].num[NW-i]};
      if (t >= {1'b0, st_r[i-1].den}) begin
        st_nxt[i].rem = t - {1'b0, st_r[i-1].den};
        st_nxt[i].quo = {st_r[i-1].quo[NW-2:0], 1'b1};
      end else begin
        st_nxt[i].rem = t;
        st_nxt[i].quo = {st_r[i-1].quo[NW-2:0], 1'b0};
      end
    end
    st_nxt[ST-1] = st_r[ST-2];
    st_nxt[ST-1].prod = 64'(fin(st_r[ST-2]));
    st_nxt[ST-1].quo = NW'(st_r[ST-2].command == CMD_DIV && st_r[ST-2].den == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ST; i++) v_r[i] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= q_valid;
      for (int i = 1; i < ST; i++) v_r[i] <= v_r[i-1];
    end
    if (adv) begin
      for (int i = 0; i < ST; i++) st_r[i] <= st_nxt[i];
    end
  end

  assign out_valid = v_r[ST-1];
  assign out_result = st_r[ST-1].prod[31:0];
  assign out_lt = st_r[ST-1].lt;
  assign out_eq = st_r[ST-1].eq;
  assign out_gt = st_r[ST-1].gt;
  assign out_dbz = st_r[ST-1].quo[0];
endmodule

@@ design/fixed_point_q24_8_alu.sv @@
// Top level of the Q24.8 fixed-point ALU: front classifier, queue and
// pipelined back end. Depends on fpa_pkg, fpa_if, fpa_front and fpa_back.
//
//  channel | direction | contents
//  in_     | sink      | command, operand_a, operand_b
//  out_    | source    | result, flag bits, divide_by_zero
//
// One request is accepted every cycle while the output is not stalled; each
// result passes through the queue and the bit-per-stage divider pipeline.
// Reset is synchronous and active low and empties the queue and pipeline.
// A stalled output freezes the pipeline and the two-entry queue then fills
// before the input stops taking requests.
module fixed_point_q24_8_alu import fpa_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  fpa_in_if.sink in_ch,
  fpa_out_if.source out_ch
);
  logic q_valid, q_ready;
  fpa_req_t q_req;

  fpa_front #(.WORD_BITS(WORD_BITS)) u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_command(in_ch.command), .in_a(in_ch.operand_a), .in_b(in_ch.operand_b),
    .q_valid, .q_ready, .q_req
  );

  fpa_back #(.WORD_BITS(WORD_BITS), .FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_req,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_result(out_ch.result), .out_lt(out_ch.a_less),
    .out_eq(out_ch.a_equal), .out_gt(out_ch.a_greater),
    .out_dbz(out_ch.divide_by_zero)
  );
endmodule
